// ===== rtl/auto_hide_fade_controller_defines.svh =====
// Assertion macros used by the checker module.
`ifndef AUTO_HIDE_FADE_CONTROLLER_DEFINES_SVH
`define AUTO_HIDE_FADE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AHFC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AHFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ahfc_pkg.sv =====
package ahfc_pkg;

  // Event codes of one input item
  typedef enum logic [3:0] {
    ACT_TICK      = 4'd0,
    ACT_TYPED     = 4'd1,
    ACT_POINTER   = 4'd2,
    ACT_AUTOHIDE  = 4'd3,
    ACT_PIN       = 4'd4,
    ACT_INTERACT  = 4'd5,
    ACT_REVEAL    = 4'd6,
    ACT_HIDE_NOW  = 4'd7,
    ACT_DITHER    = 4'd8
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HIDE_DELAY  = 2'd0,
    CFG_REVEAL_FADE = 2'd1,
    CFG_HIDE_FADE   = 2'd2,
    CFG_EDGE_ZONE   = 2'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the input fields
    logic eval;    // register fade distance, period product and edge band
    logic commit;  // update state and load the result register
  } ctrl_cmd_t;

  // Reset values of the configuration registers
  localparam logic [15:0] HIDE_DELAY_RST  = 16'd1500;
  localparam logic [15:0] REVEAL_FADE_RST = 16'd120;
  localparam logic [15:0] HIDE_FADE_RST   = 16'd400;
  localparam logic [7:0]  EDGE_ZONE_RST   = 8'd8;

  // ceil(2^17 / 3): x / 3 == (x * RECIP3) >> 17 for every 16-bit x
  localparam logic [15:0] RECIP3       = 16'd43691;
  localparam int          RECIP3_SHIFT = 17;

  // Dither threshold scale per uncovered step
  localparam int BAYER_SCALE = 4;

  // 4x4 ordered-dither thresholds, indexed [row][column]
  localparam logic [3:0] BAYER_TABLE [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6 },
    '{4'd3,  4'd11, 4'd1,  4'd9 },
    '{4'd15, 4'd7,  4'd13, 4'd5 }
  };

endpackage

// ===== rtl/ahfc_ctrl.sv =====
module ahfc_ctrl
  import ahfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequence one item: capture, evaluate, commit when the result slot frees
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the result until its transfer
  assign out_valid_next = cmd.commit | (out_valid & out_stall);

endmodule

// ===== rtl/ahfc_dp.sv =====
module ahfc_dp
  import ahfc_pkg::*;
#(
  parameter int STEP_LEVELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [3:0]         action,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        pos_x,
  input  logic [14:0]        area_height,
  input  logic [7:0]         pixel_pitch,
  input  logic               flag_value,
  input  logic signed [4:0]  dither_step,
  output logic [2:0]         overlay_step,
  output logic               step_changed,
  output logic               covered,
  output logic               hide_delay_active,
  output logic               fade_active
);

  localparam logic [2:0] LEVEL_TOP = 3'(STEP_LEVELS);

  // Configuration registers
  logic [15:0] hide_delay_ms;
  logic [15:0] reveal_fade_ms;
  logic [15:0] hide_fade_ms;
  logic [7:0]  edge_zone_pixels;

  // Captured input item
  action_t            act_q;
  logic signed [15:0] pos_y_q;
  logic [1:0]         pos_x_q;
  logic [14:0]        height_q;
  logic [7:0]         pitch_q;
  logic               flag_q;
  logic signed [4:0]  dstep_q;

  // Controller state
  logic [2:0]  level, level_next;
  logic [2:0]  fade_goal, fade_goal_next;
  logic [15:0] delay_count, delay_count_next;
  logic        delay_running, delay_running_next;
  logic [15:0] fade_period, fade_period_next;
  logic [15:0] fade_count, fade_count_next;
  logic        fade_running, fade_running_next;
  logic        auto_hide_on, auto_hide_on_next;
  logic        pinned_flag, pinned_flag_next;
  logic        interacting, interacting_next;
  logic        in_edge_band, in_edge_band_next;
  logic        typed_once, typed_once_next;

  // Evaluate-stage registers
  logic [2:0]  dist_q;
  logic [15:0] total_q;
  logic [31:0] prod_q;
  logic [15:0] edge_q;

  // Evaluate-stage logic
  logic        fade_due;
  logic        fade_fire;
  logic [2:0]  level_after;
  logic        is_tick;
  logic [2:0]  lvl_base;
  logic [2:0]  goal_sel;
  logic [2:0]  step_dist;
  logic [15:0] total_sel;
  logic [7:0]  pitch_eff;

  // Commit-stage logic
  logic        delay_due;
  logic [15:0] per_div;
  logic [15:0] per_val;
  logic signed [17:0] y_ext, h_ext, e_ext;
  logic        in_band;
  logic [2:0]  dstep_clamp;
  logic [4:0]  cov_limit;
  logic        hide_ok;
  logic        changed;
  logic        covered_next;
  logic        restart;
  logic        start_req;
  logic [2:0]  start_goal;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hide_delay_ms    <= HIDE_DELAY_RST;
      reveal_fade_ms   <= REVEAL_FADE_RST;
      hide_fade_ms     <= HIDE_FADE_RST;
      edge_zone_pixels <= EDGE_ZONE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HIDE_DELAY:  hide_delay_ms    <= cfg_data;
        CFG_REVEAL_FADE: reveal_fade_ms   <= cfg_data;
        CFG_HIDE_FADE:   hide_fade_ms     <= cfg_data;
        CFG_EDGE_ZONE:   edge_zone_pixels <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= action_t'(action);
      pos_y_q  <= pos_y;
      pos_x_q  <= pos_x[1:0];
      height_q <= area_height;
      pitch_q  <= pixel_pitch;
      flag_q   <= flag_value;
      dstep_q  <= dither_step;
    end
  end

  // Find the level a fade would start from and its distance to the goal
  always_comb begin
    fade_due    = ({1'b0, fade_count} + 17'd1) >= {1'b0, fade_period};
    fade_fire   = fade_running && fade_due && (fade_goal != level);
    level_after = level;
    if (fade_fire) begin
      level_after = (fade_goal > level) ? level + 3'd1 : level - 3'd1;
    end
    is_tick   = (act_q == ACT_TICK);
    lvl_base  = is_tick ? level_after : level;
    goal_sel  = is_tick ? 3'd0 : LEVEL_TOP;
    step_dist = (goal_sel > lvl_base) ? goal_sel - lvl_base : lvl_base - goal_sel;
    total_sel = is_tick ? hide_fade_ms : reveal_fade_ms;
    pitch_eff = (pitch_q == 8'd0) ? 8'd1 : pitch_q;
  end

  // Register the reciprocal product and the edge band height
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      dist_q  <= step_dist;
      total_q <= total_sel;
      prod_q  <= total_sel * RECIP3;
      edge_q  <= edge_zone_pixels * pitch_eff;
    end
  end

  // Fade period: total time over step distance, at least one tick
  always_comb begin
    case (dist_q)
      3'd1:    per_div = total_q;
      3'd2:    per_div = {1'b0, total_q[15:1]};
      3'd3:    per_div = 16'(prod_q >> RECIP3_SHIFT);
      default: per_div = {2'b00, total_q[15:2]};
    endcase
    per_val = (per_div == 16'd0) ? 16'd1 : per_div;
  end

  // Edge band test and dither threshold
  always_comb begin
    y_ext   = 18'(pos_y_q);
    h_ext   = $signed({3'b000, height_q});
    e_ext   = $signed({2'b00, edge_q});
    in_band = (y_ext >= 18'sd0) && (y_ext < h_ext) &&
              ((y_ext < e_ext) || (y_ext >= h_ext - e_ext));
    if (dstep_q < 5'sd0) begin
      dstep_clamp = 3'd0;
    end else if (dstep_q > $signed({2'b00, LEVEL_TOP})) begin
      dstep_clamp = LEVEL_TOP;
    end else begin
      dstep_clamp = dstep_q[2:0];
    end
    cov_limit = 5'({2'b00, LEVEL_TOP - dstep_clamp} * BAYER_SCALE);
  end

  // Apply one event to the state
  always_comb begin
    level_next         = level;
    fade_goal_next     = fade_goal;
    delay_count_next   = delay_count;
    delay_running_next = delay_running;
    fade_period_next   = fade_period;
    fade_count_next    = fade_count;
    fade_running_next  = fade_running;
    auto_hide_on_next  = auto_hide_on;
    pinned_flag_next   = pinned_flag;
    interacting_next   = interacting;
    in_edge_band_next  = in_edge_band;
    typed_once_next    = typed_once;
    changed            = 1'b0;
    covered_next       = 1'b0;
    restart            = 1'b0;
    start_req          = 1'b0;
    start_goal         = LEVEL_TOP;
    delay_due          = ({1'b0, delay_count} + 17'd1) >= {1'b0, hide_delay_ms};
    hide_ok            = auto_hide_on && !pinned_flag && !interacting && !in_edge_band;

    unique case (act_q)
      ACT_TICK: begin
        // fade counter first, then the hide delay
        if (fade_running) begin
          if (fade_due) begin
            fade_count_next = 16'd0;
            if (level == fade_goal) begin
              fade_running_next = 1'b0;
            end else begin
              level_next = level_after;
              changed    = 1'b1;
              if (level_after == fade_goal) begin
                fade_running_next = 1'b0;
              end
            end
          end else begin
            fade_count_next = fade_count + 16'd1;
          end
        end
        if (delay_running) begin
          if (delay_due) begin
            delay_count_next   = 16'd0;
            delay_running_next = 1'b0;
            if (hide_ok) begin
              start_req  = 1'b1;
              start_goal = 3'd0;
            end
          end else begin
            delay_count_next = delay_count + 16'd1;
          end
        end
      end
      ACT_TYPED: begin
        typed_once_next = 1'b1;
        restart         = 1'b1;
      end
      ACT_POINTER: begin
        if (in_band) begin
          in_edge_band_next = 1'b1;
          start_req         = 1'b1;
        end else if (in_edge_band) begin
          in_edge_band_next = 1'b0;
          restart           = 1'b1;
        end
      end
      ACT_AUTOHIDE: begin
        if (flag_q != auto_hide_on) begin
          auto_hide_on_next = flag_q;
          start_req         = !flag_q;
          restart           = flag_q;
        end
      end
      ACT_PIN: begin
        if (flag_q != pinned_flag) begin
          pinned_flag_next = flag_q;
          start_req        = flag_q;
          restart          = !flag_q;
        end
      end
      ACT_INTERACT: begin
        if (flag_q != interacting) begin
          interacting_next = flag_q;
          start_req        = flag_q;
          restart          = !flag_q;
        end
      end
      ACT_REVEAL: begin
        start_req = 1'b1;
      end
      ACT_HIDE_NOW: begin
        delay_running_next = 1'b0;
        fade_running_next  = 1'b0;
        level_next         = 3'd0;
        changed            = (level != 3'd0);
      end
      ACT_DITHER: begin
        covered_next = {1'b0, BAYER_TABLE[pos_y_q[1:0]][pos_x_q]} < cov_limit;
      end
      default: ;
    endcase

    // Restart the hide delay when nothing holds the overlay up
    if (restart && typed_once_next && auto_hide_on_next && !pinned_flag_next &&
        !interacting_next && !in_edge_band_next) begin
      delay_count_next   = 16'd0;
      delay_running_next = 1'b1;
    end

    // Start a fade; a fade to the current level just stops the fade counter
    if (start_req) begin
      delay_running_next = 1'b0;
      if (start_goal == level_next) begin
        fade_running_next = 1'b0;
      end else begin
        fade_goal_next    = start_goal;
        fade_period_next  = per_val;
        fade_count_next   = 16'd0;
        fade_running_next = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= LEVEL_TOP;
      fade_goal     <= LEVEL_TOP;
      delay_count   <= 16'd0;
      delay_running <= 1'b0;
      fade_period   <= 16'd1;
      fade_count    <= 16'd0;
      fade_running  <= 1'b0;
      auto_hide_on  <= 1'b1;
      pinned_flag   <= 1'b0;
      interacting   <= 1'b0;
      in_edge_band  <= 1'b0;
      typed_once    <= 1'b0;
    end else if (cmd.commit) begin
      level         <= level_next;
      fade_goal     <= fade_goal_next;
      delay_count   <= delay_count_next;
      delay_running <= delay_running_next;
      fade_period   <= fade_period_next;
      fade_count    <= fade_count_next;
      fade_running  <= fade_running_next;
      auto_hide_on  <= auto_hide_on_next;
      pinned_flag   <= pinned_flag_next;
      interacting   <= interacting_next;
      in_edge_band  <= in_edge_band_next;
      typed_once    <= typed_once_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      overlay_step      <= level_next;
      step_changed      <= changed;
      covered           <= covered_next;
      hide_delay_active <= delay_running_next;
      fade_active       <= fade_running_next;
    end
  end

endmodule

// ===== rtl/auto_hide_fade_controller.sv =====
// Overlay auto-hide controller. Each input item is one event (millisecond tick,
// keystroke, pointer row, flag change, reveal, immediate hide or dither query)
// and yields exactly one result: the visibility level (0 hidden up to
// STEP_LEVELS fully visible), whether this item changed it, the dither answer
// and the running state of the hide-delay and fade counters. An item passes
// through capture, one stage that registers the fade-period reciprocal
// product and the edge-band product, then the state update that loads the
// result register. A new item is accepted in the cycle after the update, so
// the block takes no new item before the last one is through; the update
// waits only while the previous result is still stalled at the output.
// Configuration writes are always ready and take effect at once; write them
// only while no item is in flight.
module auto_hide_fade_controller
  import ahfc_pkg::*;
#(
  parameter int STEP_LEVELS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        pos_x,
  input  logic [14:0]        area_height,
  input  logic [7:0]         pixel_pitch,
  input  logic               flag_value,
  input  logic signed [4:0]  dither_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         overlay_step,
  output logic               step_changed,
  output logic               covered,
  output logic               hide_delay_active,
  output logic               fade_active,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  // Sequence items through the datapath
  ahfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Counters, flags, fade period and dither logic
  ahfc_dp #(
    .STEP_LEVELS (STEP_LEVELS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .action            (action),
    .pos_y             (pos_y),
    .pos_x             (pos_x),
    .area_height       (area_height),
    .pixel_pitch       (pixel_pitch),
    .flag_value        (flag_value),
    .dither_step       (dither_step),
    .overlay_step      (overlay_step),
    .step_changed      (step_changed),
    .covered           (covered),
    .hide_delay_active (hide_delay_active),
    .fade_active       (fade_active)
  );

endmodule

// ===== rtl/ahfc_checker.sv =====
`include "auto_hide_fade_controller_defines.svh"

module ahfc_checker #(
  parameter int STEP_LEVELS = 4
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] overlay_step,
  input logic       step_changed,
  input logic       covered,
  input logic       hide_delay_active,
  input logic       fade_active
);

  logic [6:0] res_bits;

  // Gather the result fields
  assign res_bits = {overlay_step, step_changed, covered, hide_delay_active, fade_active};

  // Hold a stalled result
  `AHFC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(res_bits), "stalled result changed or dropped")

  // One item in flight: stall right after a transfer in
  `AHFC_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && !in_stall, in_stall, "second item taken while one is in flight")

  // No result appears in the cycle after an item is taken
  `AHFC_ASSERT_NEXT(a_no_early_result, clk, rst, in_valid && !in_stall, !$rose(out_valid), "result appeared too early")

  // Level never exceeds the top step
  `AHFC_ASSERT_NOW(a_level_range, clk, rst, out_valid, overlay_step <= 3'(STEP_LEVELS), "visibility level out of range")

endmodule

bind auto_hide_fade_controller ahfc_checker #(
  .STEP_LEVELS (STEP_LEVELS)
) u_ahfc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .overlay_step      (overlay_step),
  .step_changed      (step_changed),
  .covered           (covered),
  .hide_delay_active (hide_delay_active),
  .fade_active       (fade_active)
);

// ===== verif/auto_hide_fade_controller_checker.sv =====
`timescale 1ns / 1ps

module auto_hide_fade_controller_checker
  import ahfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         action,
  input  logic signed [15:0] pos_y,
  input  logic [15:0]        pos_x,
  input  logic [14:0]        area_height,
  input  logic [7:0]         pixel_pitch,
  input  logic               flag_value,
  input  logic signed [4:0]  dither_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         overlay_step,
  input  logic               step_changed,
  input  logic               covered,
  input  logic               hide_delay_active,
  input  logic               fade_active,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 in_flight
);

  localparam int TOP_LEVEL    = 4;
  localparam int THRESH_SCALE = 4;
  localparam int MAX_REPORTS  = 30;

  // Ordered-dither thresholds, [row][column]
  localparam logic [3:0] DITHER_THRESH [4][4] = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6 },
    '{4'd3,  4'd11, 4'd1,  4'd9 },
    '{4'd15, 4'd7,  4'd13, 4'd5 }
  };

  typedef struct packed {
    logic [2:0] step;
    logic       moved;
    logic       cov;
    logic       delay_on;
    logic       fade_on;
  } status_t;

  // Expected status per accepted event, oldest first
  status_t status_due[$];

  // Configuration copy
  logic [15:0] delay_ms, reveal_ms, hide_ms;
  logic [7:0]  zone_px;

  // Controller state copy
  logic [2:0]  vis_level, goal_level;
  logic [15:0] delay_cnt, fade_per, fade_cnt;
  logic        delay_run, fade_run, autohide_en, pinned, interacting_now;
  logic        edge_hold, has_typed, step_moved;

  task automatic log_mismatch(string what, int got_v, int want_v);
    if (fail_count < MAX_REPORTS)
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
    fail_count++;
  endtask

  function automatic void move_level(int v);
    if (v > TOP_LEVEL) v = TOP_LEVEL;
    if (v != int'(vis_level)) begin
      vis_level  = v[2:0];
      step_moved = 1'b1;
    end
  endfunction

  // Aim the fade at a goal; a goal equal to the level just stops the fade
  function automatic void launch_fade(int goal, int total);
    int step_dist, per;
    if (goal == int'(vis_level)) begin
      fade_run = 1'b0;
      return;
    end
    goal_level = goal[2:0];
    step_dist = goal > int'(vis_level) ? goal - int'(vis_level) : int'(vis_level) - goal;
    per = total / step_dist;
    if (per < 1) per = 1;
    fade_per = per[15:0];
    fade_cnt = '0;
    fade_run = 1'b1;
  endfunction

  function automatic void reveal_now();
    delay_run = 1'b0;
    launch_fade(TOP_LEVEL, int'(reveal_ms));
  endfunction

  function automatic void rearm_delay();
    if (has_typed && autohide_en && !pinned && !interacting_now && !edge_hold) begin
      delay_cnt = '0;
      delay_run = 1'b1;
    end
  endfunction

  function automatic void begin_fade_out();
    if (!autohide_en || pinned || interacting_now || edge_hold) return;
    launch_fade(0, int'(hide_ms));
  endfunction

  function automatic void fade_tick();
    if (vis_level == goal_level) begin
      fade_run = 1'b0;
      return;
    end
    move_level(goal_level > vis_level ? int'(vis_level) + 1 : int'(vis_level) - 1);
    if (vis_level == goal_level) fade_run = 1'b0;
  endfunction

  function automatic void flag_moved(logic reveals);
    if (reveals) reveal_now();
    else rearm_delay();
  endfunction

  // Advance the state copy by the event on the input ports
  function automatic status_t apply_event();
    status_t res;
    int      y, h, s, band_px;
    logic    hit;
    step_moved = 1'b0;
    res.cov = 1'b0;
    y = pos_y;
    h = area_height;
    case (action)
      ACT_TICK: begin
        // fade counter first, then the delay counter
        if (fade_run) begin
          if (int'(fade_cnt) + 1 >= int'(fade_per)) begin
            fade_cnt = '0;
            fade_tick();
          end else begin
            fade_cnt++;
          end
        end
        if (delay_run) begin
          if (int'(delay_cnt) + 1 >= int'(delay_ms)) begin
            delay_cnt = '0;
            delay_run = 1'b0;
            begin_fade_out();
          end else begin
            delay_cnt++;
          end
        end
      end
      ACT_TYPED: begin
        has_typed = 1'b1;
        rearm_delay();
      end
      ACT_POINTER: begin
        band_px = int'(zone_px) * (pixel_pitch == 8'd0 ? 1 : int'(pixel_pitch));
        hit = y >= 0 && y < h && (y < band_px || y >= h - band_px);
        if (hit) begin
          edge_hold = 1'b1;
          reveal_now();
        end else if (edge_hold) begin
          edge_hold = 1'b0;
          rearm_delay();
        end
      end
      ACT_AUTOHIDE: begin
        if (autohide_en != flag_value) begin
          autohide_en = flag_value;
          flag_moved(!flag_value);
        end
      end
      ACT_PIN: begin
        if (pinned != flag_value) begin
          pinned = flag_value;
          flag_moved(flag_value);
        end
      end
      ACT_INTERACT: begin
        if (interacting_now != flag_value) begin
          interacting_now = flag_value;
          flag_moved(flag_value);
        end
      end
      ACT_REVEAL: reveal_now();
      ACT_HIDE_NOW: begin
        delay_run = 1'b0;
        fade_run  = 1'b0;
        move_level(0);
      end
      ACT_DITHER: begin
        s = dither_step;
        if (s < 0) s = 0;
        if (s > TOP_LEVEL) s = TOP_LEVEL;
        res.cov = int'(DITHER_THRESH[pos_y[1:0]][pos_x[1:0]]) < (TOP_LEVEL - s) * THRESH_SCALE;
      end
      default: ;
    endcase
    res.step     = vis_level;
    res.moved    = step_moved;
    res.delay_on = delay_run;
    res.fade_on  = fade_run;
    return res;
  endfunction

  // Track config writes, check results, predict accepted events
  always @(posedge clk) begin : watch
    status_t got, want;
    if (rst) begin
      delay_ms        = HIDE_DELAY_RST;
      reveal_ms       = REVEAL_FADE_RST;
      hide_ms         = HIDE_FADE_RST;
      zone_px         = EDGE_ZONE_RST;
      vis_level       = 3'(TOP_LEVEL);
      goal_level      = 3'(TOP_LEVEL);
      delay_cnt       = '0;
      delay_run       = 1'b0;
      fade_per        = 16'd1;
      fade_cnt        = '0;
      fade_run        = 1'b0;
      autohide_en     = 1'b1;
      pinned          = 1'b0;
      interacting_now = 1'b0;
      edge_hold       = 1'b0;
      has_typed       = 1'b0;
      status_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HIDE_DELAY:  delay_ms  = cfg_data;
          CFG_REVEAL_FADE: reveal_ms = cfg_data;
          CFG_HIDE_FADE:   hide_ms   = cfg_data;
          CFG_EDGE_ZONE:   zone_px   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {overlay_step, step_changed, covered, hide_delay_active, fade_active};
        if (status_due.size() == 0) begin
          log_mismatch("result with no event pending", int'(got.step), -1);
        end else begin
          want = status_due.pop_front();
          if (got.step !== want.step)
            log_mismatch("overlay_step", int'(got.step), int'(want.step));
          if (got.moved !== want.moved)
            log_mismatch("step_changed", int'(got.moved), int'(want.moved));
          if (got.cov !== want.cov)
            log_mismatch("covered", int'(got.cov), int'(want.cov));
          if (got.delay_on !== want.delay_on)
            log_mismatch("hide_delay_active", int'(got.delay_on), int'(want.delay_on));
          if (got.fade_on !== want.fade_on)
            log_mismatch("fade_active", int'(got.fade_on), int'(want.fade_on));
        end
      end
      if (in_valid && !in_stall) status_due.push_back(apply_event());
    end
    in_flight = status_due.size();
  end

endmodule

// ===== verif/auto_hide_fade_controller_tb.sv =====
`timescale 1ns / 1ps

module auto_hide_fade_controller_tb
  import ahfc_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 235;
  localparam int SETTLE       = 10;

  // Codes the block ignores
  localparam logic [3:0] ACT_SPARE_LO = 4'd9;
  localparam logic [3:0] ACT_SPARE_HI = 4'd15;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         action;
  logic signed [15:0] pos_y;
  logic [15:0]        pos_x;
  logic [14:0]        area_height;
  logic [7:0]         pixel_pitch;
  logic               flag_value;
  logic signed [4:0]  dither_step;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         overlay_step;
  logic               step_changed;
  logic               covered;
  logic               hide_delay_active;
  logic               fade_active;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  int   mismatches;
  int   in_flight;
  int   sent;
  int   cycles;
  int   calm_left;
  bit   quiet;
  bit   hold_done;
  logic [7:0] zone_now;

  auto_hide_fade_controller dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .pos_y             (pos_y),
    .pos_x             (pos_x),
    .area_height       (area_height),
    .pixel_pitch       (pixel_pitch),
    .flag_value        (flag_value),
    .dither_step       (dither_step),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .overlay_step      (overlay_step),
    .step_changed      (step_changed),
    .covered           (covered),
    .hide_delay_active (hide_delay_active),
    .fade_active       (fade_active),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  auto_hide_fade_controller_checker chk (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .action            (action),
    .pos_y             (pos_y),
    .pos_x             (pos_x),
    .area_height       (area_height),
    .pixel_pitch       (pixel_pitch),
    .flag_value        (flag_value),
    .dither_step       (dither_step),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .overlay_step      (overlay_step),
    .step_changed      (step_changed),
    .covered           (covered),
    .hide_delay_active (hide_delay_active),
    .fade_active       (fade_active),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (mismatches),
    .in_flight         (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output stall pattern: random bursts, calm stretches, one long hold-off
  initial begin : result_stall
    int run_left;
    bit hold_next;
    run_left  = 0;
    hold_next = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        if (quiet) begin
          hold_next = 1'b0;
          run_left  = 1;
        end else if (!hold_done && sent >= HOLD_AFTER) begin
          hold_next = 1'b1;
          run_left  = HOLD_CYCLES;
          hold_done = 1'b1;
        end else begin
          case ($urandom_range(0, 5))
            0, 1: begin
              hold_next = 1'b1;
              run_left  = $urandom_range(1, 14);
            end
            2: begin
              hold_next = 1'b0;
              run_left  = $urandom_range(40, 120);
            end
            default: begin
              hold_next = 1'b0;
              run_left  = $urandom_range(1, 20);
            end
          endcase
        end
      end
      out_stall <= hold_next;
      run_left--;
    end
  end

  // Offer one event, with an optional gap first, and hold it until transfer
  task automatic push_item(input logic [3:0] act, input logic [15:0] y, input logic [15:0] x,
                           input logic [14:0] h, input logic [7:0] p, input logic fv,
                           input logic [4:0] ds);
    int gap;
    if (!quiet && calm_left == 0 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(20, 60);
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= act;
    pos_y       <= y;
    pos_x       <= x;
    area_height <= h;
    pixel_pitch <= p;
    flag_value  <= fv;
    dither_step <= ds;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [15:0] delay, input logic [15:0] rise,
                           input logic [15:0] fall, input logic [15:0] zone);
    drain();
    write_reg(CFG_HIDE_DELAY, delay);
    write_reg(CFG_REVEAL_FADE, rise);
    write_reg(CFG_HIDE_FADE, fall);
    write_reg(CFG_EDGE_ZONE, zone);
    @(negedge clk);
    cfg_valid <= 1'b0;
    zone_now = zone[7:0];
  endtask

  initial begin : stimulus
    int         r, yi, span, phase, n;
    logic [3:0] act;
    logic [15:0] y, x;
    logic [14:0] h;
    logic [7:0] p;
    logic       fv;
    logic [4:0] ds;

    rst         = 1'b1;
    in_valid    = 1'b0;
    action      = ACT_TICK;
    pos_y       = '0;
    pos_x       = '0;
    area_height = '0;
    pixel_pitch = '0;
    flag_value  = 1'b0;
    dither_step = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_HIDE_DELAY;
    cfg_data    = '0;
    quiet       = 1'b0;
    calm_left   = 0;
    zone_now    = EDGE_ZONE_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed events on the reset configuration
    push_item(ACT_TICK, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    // dither with the step clamped low, clamped high, and in range
    push_item(ACT_DITHER, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'h18);
    push_item(ACT_DITHER, 16'hFFFF, 16'hFFFF, 15'h7FFF, 8'hFF, 1'b1, 5'h0F);
    push_item(ACT_DITHER, 16'h0001, 16'h0002, 15'd0, 8'd0, 1'b0, 5'd2);
    push_item(ACT_TYPED, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    // top band with pitch zero, leave, extremes, bottom band, leave
    push_item(ACT_POINTER, 16'd3, 16'h0000, 15'd600, 8'd0, 1'b0, 5'd0);
    push_item(ACT_POINTER, 16'd300, 16'h0000, 15'd600, 8'd1, 1'b0, 5'd0);
    push_item(ACT_POINTER, 16'h8000, 16'h0000, 15'h7FFF, 8'hFF, 1'b0, 5'd0);
    push_item(ACT_POINTER, 16'h7FFF, 16'h0000, 15'h7FFF, 8'd1, 1'b0, 5'd0);
    push_item(ACT_POINTER, 16'd595, 16'h0000, 15'd600, 8'd1, 1'b0, 5'd0);
    push_item(ACT_POINTER, 16'd300, 16'h0000, 15'd600, 8'd1, 1'b0, 5'd0);
    // hide at once, then reveal twice to restart the fade
    push_item(ACT_HIDE_NOW, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    push_item(ACT_TICK, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    push_item(ACT_REVEAL, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    push_item(ACT_TICK, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    push_item(ACT_REVEAL, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    // flag writes, the first one repeating the held value
    push_item(ACT_AUTOHIDE, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b1, 5'd0);
    push_item(ACT_AUTOHIDE, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    push_item(ACT_AUTOHIDE, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b1, 5'd0);
    push_item(ACT_PIN, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b1, 5'd0);
    push_item(ACT_PIN, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b1, 5'd0);
    push_item(ACT_PIN, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    push_item(ACT_INTERACT, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b1, 5'd0);
    push_item(ACT_INTERACT, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);
    push_item(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 15'h7FFF, 8'hFF, 1'b1, 5'h1F);
    push_item(ACT_SPARE_HI, 16'h0000, 16'h0000, 15'd0, 8'd0, 1'b0, 5'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      // Reset settings first, then zeros, maxima, tight values, random small ones
      case (phase)
        0: ;
        1: configure(16'd0, 16'd0, 16'd0, 16'd0);
        2: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
        3: configure(16'd1, 16'd1, 16'd3, 16'd1);
        default: configure(16'($urandom_range(1, 12)), 16'($urandom_range(0, 16)),
                           16'($urandom_range(0, 24)), 16'($urandom_range(0, 12)));
      endcase
      if (phase == PHASES - 1) quiet = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50)      act = ACT_TICK;
        else if (r < 58) act = ACT_TYPED;
        else if (r < 70) act = ACT_POINTER;
        else if (r < 74) act = ACT_AUTOHIDE;
        else if (r < 78) act = ACT_PIN;
        else if (r < 82) act = ACT_INTERACT;
        else if (r < 86) act = ACT_REVEAL;
        else if (r < 90) act = ACT_HIDE_NOW;
        else if (r < 97) act = ACT_DITHER;
        else             act = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        y  = 16'($urandom);
        x  = 16'($urandom);
        h  = 15'($urandom);
        p  = 8'($urandom);
        fv = 1'($urandom);
        ds = 5'($urandom);
        case (act)
          ACT_POINTER: begin
            // aim mostly near the bands of a modest window
            if ($urandom_range(0, 7) != 0) begin
              h = 15'($urandom_range(0, 400));
              p = 8'($urandom_range(0, 3));
            end
            span = int'(zone_now) * (p == 8'd0 ? 1 : int'(p));
            yi = int'(y);
            case ($urandom_range(0, 3))
              0: yi = $urandom_range(0, span);
              1: yi = int'(h) - 1 - int'($urandom_range(0, span));
              2: yi = $urandom_range(0, int'(h));
              default: ;
            endcase
            y = yi[15:0];
          end
          ACT_AUTOHIDE: fv = ($urandom_range(0, 3) != 0);
          ACT_PIN, ACT_INTERACT: fv = ($urandom_range(0, 3) == 0);
          default: ;
        endcase
        push_item(act, y, x, h, p, fv, ds);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
